[hw/rtl/fehg_pkg.sv]
// Shared types and constants for the fire effect heat grid unit.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fehg_pkg;

  // Default grid size
  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 8;

  // Port widths
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int COL_W      = 5;
  localparam int ROW_W      = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COOLING  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARKING = 8'd1;

  localparam logic [BYTE_W-1:0] COOLING_RST  = 8'd55;
  localparam logic [BYTE_W-1:0] SPARKING_RST = 8'd120;

  // Cooling factor is cooling*10/height + 2
  localparam int COOL_SCALE  = 10;
  localparam int FACTOR_BIAS = 2;

  // x/3 for x < 2048 as (x*683) >> 11
  localparam logic [19:0] DIV3_MUL   = 20'd683;
  localparam int          DIV3_SHIFT = 11;

  // heat*191/255 as (heat * 191*ceil(2^24/255)) >> 24, exact for 8-bit heat
  localparam logic [31:0] PAL_MUL   = 32'd12566654;
  localparam int          PAL_SHIFT = 24;

  // Spark heat is 160 + (rand*95 >> 8)
  localparam logic [8:0]  SPARK_BASE  = 9'd160;
  localparam logic [15:0] SPARK_SCALE = 16'd95;

  // Controller to datapath commands
  typedef struct packed {
    logic             rd_en;     // heat store read
    logic             in_load;   // capture input request
    logic             cool;      // cool the cell just read
    logic             fresh;     // grid not yet written once: read as zero
    logic             wr_en;     // heat store write
    logic             wr_spark;  // write bottom row with spark, else diffused value
    logic             em_rd;     // pixel read for emission
    logic             em_last;   // pixel is the column's bottom row
    logic             em_frame;  // pixel is the grid's last
    logic [COL_W-1:0] em_col;
    logic [ROW_W-1:0] em_row;
    logic             out_load;  // load output register from read data
  } cmd_t;

endpackage

[hw/rtl/fehg_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fehg_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fehg_ctrl.sv]
// Sequencer for the heat grid: cell handshake, column write-back, pixel emission.
// Depends on fehg_pkg.
`timescale 1ns / 1ps

module fehg_ctrl #(
  parameter int GRID_WIDTH  = fehg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = fehg_pkg::GRID_HEIGHT_DEF,
  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           m_ready_i,
  output logic           m_valid_o,
  output fehg_pkg::cmd_t cmd_o,
  output logic [AW-1:0]  rd_addr_o,
  output logic [AW-1:0]  wr_addr_o
);

  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int KW = $clog2(GRID_HEIGHT + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CELL  = 3'd1;
  localparam logic [2:0] S_END_A = 3'd2;
  localparam logic [2:0] S_END_B = 3'd3;
  localparam logic [2:0] S_END_C = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [YW-1:0] row_q, row_d;
  logic [XW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;
  logic          filled_q, filled_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [KW-1:0] k_q, k_d;
  logic          rd_vld_q, rd_vld_d;
  logic          out_vld_q, out_vld_d;

  logic accept, load_out, em_issue, col_last;

  assign accept   = (state_q == S_IDLE) && s_valid_i;
  assign load_out = rd_vld_q && (!out_vld_q || m_ready_i);
  assign em_issue = (state_q == S_EMIT) && (k_q != KW'(GRID_HEIGHT)) &&
                    (!rd_vld_q || load_out);
  assign col_last = (32'(col_q) == GRID_WIDTH - 1);

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_vld_q;

  // read address: cell read on accept, pixel read during emission
  assign rd_addr_o = accept ? base_q + AW'(row_q) : base_q + AW'(k_q[YW-1:0]);

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_en    = accept || em_issue;
    cmd_o.in_load  = accept;
    cmd_o.cool     = (state_q == S_CELL);
    cmd_o.fresh    = !filled_q;
    cmd_o.em_rd    = em_issue;
    cmd_o.em_last  = (32'(k_q) == GRID_HEIGHT - 1);
    cmd_o.em_frame = (32'(k_q) == GRID_HEIGHT - 1) && col_last;
    cmd_o.em_col   = fehg_pkg::COL_W'(col_q);
    cmd_o.em_row   = fehg_pkg::ROW_W'(k_q);
    cmd_o.out_load = load_out;
    wr_addr_o      = wr_addr_q;
    if (wr_pend_q) begin
      cmd_o.wr_en = 1'b1;
    end else if (state_q == S_END_B) begin
      cmd_o.wr_en = 1'b1;
      wr_addr_o   = base_q + AW'(GRID_HEIGHT - 2);
    end else if (state_q == S_END_C) begin
      cmd_o.wr_en    = 1'b1;
      cmd_o.wr_spark = 1'b1;
      wr_addr_o      = base_q + AW'(GRID_HEIGHT - 1);
    end
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    base_d    = base_q;
    filled_d  = filled_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    k_d       = k_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        // two rows cooled: diffused value for two rows up is ready next cycle
        if (32'(row_q) >= 32'd2) begin
          wr_pend_d = 1'b1;
          wr_addr_d = base_q + AW'(row_q - YW'(2));
        end
        if (32'(row_q) == GRID_HEIGHT - 1) begin
          row_d   = '0;
          state_d = S_END_A;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_END_A: state_d = S_END_B;
      S_END_B: state_d = S_END_C;
      S_END_C: begin
        k_d     = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (em_issue) begin
          k_d = k_q + 1'b1;
        end
        if ((k_q == KW'(GRID_HEIGHT)) && !rd_vld_q) begin
          state_d = S_IDLE;
          if (col_last) begin
            col_d    = '0;
            base_d   = '0;
            filled_d = 1'b1;
          end else begin
            col_d  = col_q + 1'b1;
            base_d = base_q + AW'(GRID_HEIGHT);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (em_issue) begin
      rd_vld_d = 1'b1;
    end else if (load_out) begin
      rd_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      base_q    <= '0;
      filled_q  <= 1'b0;
      wr_pend_q <= 1'b0;
      wr_addr_q <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      base_q    <= base_d;
      filled_q  <= filled_d;
      wr_pend_q <= wr_pend_d;
      wr_addr_q <= wr_addr_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

[hw/rtl/fehg_dpath.sv]
// Datapath: config registers, cooling, diffusion, spark, heat store and palette.
// Depends on fehg_pkg and fehg_ram.
`timescale 1ns / 1ps

module fehg_dpath #(
  parameter int GRID_WIDTH  = fehg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = fehg_pkg::GRID_HEIGHT_DEF,
  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fehg_pkg::cmd_t                      cmd_i,
  input  logic [AW-1:0]                       rd_addr_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic [fehg_pkg::IN_DATA_W-1:0]      s_data_i,
  input  logic                                cfg_valid_i,
  input  logic [fehg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fehg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [fehg_pkg::OUT_DATA_W-1:0]     m_data_o,
  output logic                                m_last_o,
  output logic                                m_frame_o
);

  // cooling*10/height by reciprocal, exact for the 12-bit product
  localparam int          FAC_SHIFT = 12 + $clog2(GRID_HEIGHT);
  localparam logic [31:0] FAC_MUL   =
    32'(((64'd1 << FAC_SHIFT) + GRID_HEIGHT - 1) / GRID_HEIGHT);
  localparam logic [10:0] FACTOR_RST = 11'(32'(fehg_pkg::COOLING_RST) *
    fehg_pkg::COOL_SCALE / GRID_HEIGHT + fehg_pkg::FACTOR_BIAS);

  logic [7:0]  cooling_q, sparking_q;
  logic [10:0] factor_q, factor_d;
  logic [7:0]  cool_rand_q, spark_roll_q, spark_rand_q;
  logic [7:0]  h_prev_q, h_cur_q;
  logic [fehg_pkg::COL_W-1:0] em_col_q;
  logic [fehg_pkg::ROW_W-1:0] em_row_q;
  logic        em_last_q, em_frame_q;
  logic [fehg_pkg::OUT_DATA_W-1:0] m_data_q;
  logic        m_last_q, m_frame_q;

  logic [7:0]  ram_rdata, ram_wdata;
  logic [11:0] cool_x10;
  logic [31:0] fac_prod;
  logic [18:0] amt_prod;
  logic [10:0] amount;
  logic [7:0]  cur, cooled;
  logic [9:0]  diff_sum;
  logic [19:0] diff_prod;
  logic [7:0]  diff_val;
  logic [15:0] sp_prod;
  logic [8:0]  sp_sum;
  logic [7:0]  spark_val;
  logic [31:0] pal_prod;
  logic [7:0]  pal_t, ramp, red, green, blue;

  // config writes; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooling_q  <= fehg_pkg::COOLING_RST;
      sparking_q <= fehg_pkg::SPARKING_RST;
      factor_q   <= FACTOR_RST;
    end else begin
      factor_q <= factor_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fehg_pkg::CFG_IDX_COOLING:  cooling_q  <= cfg_data_i;
          fehg_pkg::CFG_IDX_SPARKING: sparking_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // factor is registered from cooling and follows it in the next cycle
  assign cool_x10 = 12'(cooling_q) * 12'(fehg_pkg::COOL_SCALE);
  assign fac_prod = 32'(cool_x10) * FAC_MUL;
  assign factor_d = 11'(fac_prod >> FAC_SHIFT) + 11'(fehg_pkg::FACTOR_BIAS);

  // cooling of the cell just read
  assign cur      = cmd_i.fresh ? 8'd0 : ram_rdata;
  assign amt_prod = 19'(cool_rand_q) * 19'(factor_q);
  assign amount   = amt_prod[18:8];
  assign cooled   = (amount >= 11'(cur)) ? 8'd0 : cur - amount[7:0];

  // diffusion (2*upper + lower)/3 over the last two cooled rows
  assign diff_sum  = {1'b0, h_prev_q, 1'b0} + 10'(h_cur_q);
  assign diff_prod = 20'(diff_sum) * fehg_pkg::DIV3_MUL;
  assign diff_val  = 8'(diff_prod >> fehg_pkg::DIV3_SHIFT);

  // spark on the bottom row, saturating
  assign sp_prod   = 16'(spark_rand_q) * fehg_pkg::SPARK_SCALE;
  assign sp_sum    = 9'(h_cur_q) + fehg_pkg::SPARK_BASE + 9'(sp_prod[15:8]);
  assign spark_val = (spark_roll_q < sparking_q) ? (sp_sum[8] ? 8'hff : sp_sum[7:0])
                                                 : h_cur_q;

  assign ram_wdata = cmd_i.wr_spark ? spark_val : diff_val;

  fehg_ram #(
    .DATA_W (8),
    .DEPTH  (GRID_WIDTH * GRID_HEIGHT)
  ) u_heat (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // three-band palette
  assign pal_prod = 32'(ram_rdata) * fehg_pkg::PAL_MUL;
  assign pal_t    = 8'(pal_prod >> fehg_pkg::PAL_SHIFT);
  assign ramp     = {pal_t[5:0], 2'b00};

  always_comb begin
    if (pal_t[7]) begin
      red = 8'hff; green = 8'hff; blue = ramp;
    end else if (pal_t[6]) begin
      red = 8'hff; green = ramp; blue = 8'd0;
    end else begin
      red = ramp; green = 8'd0; blue = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cool_rand_q  <= s_data_i[7:0];
      spark_roll_q <= s_data_i[15:8];
      spark_rand_q <= s_data_i[23:16];
    end
    if (cmd_i.cool) begin
      h_prev_q <= h_cur_q;
      h_cur_q  <= cooled;
    end
    if (cmd_i.em_rd) begin
      em_col_q   <= cmd_i.em_col;
      em_row_q   <= cmd_i.em_row;
      em_last_q  <= cmd_i.em_last;
      em_frame_q <= cmd_i.em_frame;
    end
    if (cmd_i.out_load) begin
      m_data_q  <= {blue, green, red, em_row_q, em_col_q};
      m_last_q  <= em_last_q;
      m_frame_q <= em_frame_q;
    end
  end

  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;
  assign m_frame_o = m_frame_q;

endmodule

[hw/rtl/fire_effect_heat_grid_unit.sv]
// Fire effect heat grid unit: top level, joins the sequencer and the datapath.
// Depends on fehg_pkg, fehg_ctrl, fehg_dpath (and fehg_ram below it).
// Flow: a cell request passes through the heat store read, then cooling. The column's
// last cell adds the write-back states; its first pixel then passes the read and output
// registers. No request is taken while a cell is cooled or its column is written back or
// emitted; cell reads and pixel reads share the single heat store read port.
// Reset: all control state clears at once; the heat store is not swept, its first
// pass over the grid reads as zero until every column has been written back once.
`timescale 1ns / 1ps

module fire_effect_heat_grid_unit #(
  parameter int GRID_WIDTH  = fehg_pkg::GRID_WIDTH_DEF,   // 1..32
  parameter int GRID_HEIGHT = fehg_pkg::GRID_HEIGHT_DEF   // 2..8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cell request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] cool_rand, [15:8] spark_roll, [23:16] spark_rand
  input  logic [fehg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // pixel stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [4:0] col, [7:5] row, [15:8] red, [23:16] green, [31:24] blue
  output logic [fehg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,   // bottom pixel of column
  output logic                            m_axis_tuser,   // [0] frame_end
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fehg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fehg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  fehg_pkg::cmd_t cmd;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;

  // registers are plain flops, always writable
  assign cfg_ready_o = 1'b1;

  // Sequencer: per cell IDLE -> CELL; on a column's last cell three write-back
  // states (pending diffusion row, row above bottom, bottom row with spark), then
  // emission streams the column back out of the heat store through a two-stage
  // read/output pipeline, one pixel a cycle when the sink keeps up.
  fehg_ctrl #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr)
  );

  // Datapath: diffusion is computed on the fly from the last two cooled rows and
  // written straight back, so no separate column buffer is kept.
  fehg_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .s_data_i    (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .m_frame_o   (m_axis_tuser)
  );

  // accepted request is cooled in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> cmd.cool)
    else $error("cell request not followed by cooling");

  // write-back and pixel reads never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && cmd.em_rd))
    else $error("heat store write during emission read");

  // no pixel reads while requests are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.em_rd)
    else $error("emission read while accepting cells");

  // frame end only on a column's bottom pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end without column end");

endmodule
